// File: rtl/sha256h_pkg.sv
// sha256h_pkg: types and constants for the sha-256 message hasher
// round constants, initial hash value and sequencer state type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sha256h_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned PAD_LIMIT = 56;

   typedef logic [31:0] word_type;
   typedef word_type block_type [16];
   typedef word_type hash_type [8];

   typedef struct packed {
      logic start;
      logic init;
   } core_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FULL,
      ST_FULL_WAIT,
      ST_PAD,
      ST_PAD_WAIT,
      ST_LEN,
      ST_LEN_WAIT,
      ST_EMIT
   } seq_state_type;

endpackage
`default_nettype wire

// File: rtl/sha256h_core.sv
// sha256h_core: one-round-per-cycle sha-256 compression with a rolling
// 16-word message schedule window and the eight running hash words
// depends on sha256h_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha256h_core (
   input  wire                          clock,
   input  wire                          reset,
   input  sha256h_pkg::core_cmd_type    cmd,
   input  sha256h_pkg::block_type       block,
   output logic                         done,
   output sha256h_pkg::hash_type        hash
);

   sha256h_pkg::hash_type  hash_ff, hash_in;
   sha256h_pkg::hash_type  v_ff, v_in;
   sha256h_pkg::block_type w_ff, w_in;
   logic [5:0] rnd_ff, rnd_in;
   logic       busy_ff, busy_in;
   logic       add_ff, add_in;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0] t1, t2, s0, s1, e, a;

   always_comb begin
      e  = v_ff[4];
      a  = v_ff[0];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + sha256h_pkg::ROUND_K[rnd_ff] + w_ff[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);

      hash_in = hash_ff;
      v_in    = v_ff;
      w_in    = w_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      add_in  = 1'b0;

      if (cmd.start) begin
         v_in    = hash_ff;
         w_in    = block;
         rnd_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = w_ff[0] + s0 + w_ff[9] + s1;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
         rnd_in  = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            add_in  = 1'b1;
         end
      end else if (add_ff) begin
         for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i] + v_ff[i];
      end

      if (cmd.init) hash_in = sha256h_pkg::INIT_HASH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= sha256h_pkg::INIT_HASH;
         busy_ff <= 1'b0;
         add_ff  <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         busy_ff <= busy_in;
         add_ff  <= add_in;
         rnd_ff  <= rnd_in;
      end
      v_ff <= v_in;
      w_ff <= w_in;
   end

   assign done = add_ff;
   assign hash = hash_ff;

endmodule
`default_nettype wire

// File: rtl/sha256_message_hasher.sv
// sha256_message_hasher: byte collector, padding and digest sequencer
// around the shared compression round unit
// depends on sha256h_pkg and sha256h_core
`timescale 1ns / 1ps
`default_nettype none
// one request per cycle while the 64-byte buffer is filling; the request that
// fills the buffer is followed by a stall for its compression (a start step, 64
// rounds through the single round unit, a hash add step)
// a final request takes one or two further compressions before the first
// digest word, then one word per cycle unless stalled
// synchronous reset returns the hash words to the initial value and clears counts
module sha256_message_hasher (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_byte_valid,
   input  wire         req_final_item,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha256h_pkg::seq_state_type state_ff, state_in;
   sha256h_pkg::block_type     buf_ff;
   sha256h_pkg::block_type     blk;
   sha256h_pkg::block_type     pad_blk;
   sha256h_pkg::hash_type      hash;
   sha256h_pkg::core_cmd_type  cmd;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic        fin_ff, fin_in;
   logic [2:0]  idx_ff, idx_in;
   logic        done;
   logic        accept;

   sha256h_core u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .block (blk),
      .done  (done),
      .hash  (hash)
   );

   assign accept = req_valid && !req_stall;

   // padded copy of the buffer: data bytes, then the marker byte, then zeros
   always_comb begin
      for (int j = 0; j < 16; j++) begin
         for (int b = 0; b < 4; b++) begin
            if (6'(4 * j + b) < fill_ff)
               pad_blk[j][8 * (3 - b) +: 8] = buf_ff[j][8 * (3 - b) +: 8];
            else if (6'(4 * j + b) == fill_ff)
               pad_blk[j][8 * (3 - b) +: 8] = sha256h_pkg::PAD_BYTE;
            else
               pad_blk[j][8 * (3 - b) +: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      fin_in    = fin_ff;
      idx_in    = idx_ff;
      cmd       = '0;
      blk       = buf_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         sha256h_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               fin_in = req_final_item;
               if (req_byte_valid) begin
                  fill_in  = fill_ff + 6'd1;
                  count_in = count_ff + 61'd1;
               end
               if (req_byte_valid && fill_ff == 6'd63)
                  state_in = sha256h_pkg::ST_FULL;
               else if (req_final_item)
                  state_in = sha256h_pkg::ST_PAD;
            end
         end
         sha256h_pkg::ST_FULL: begin
            cmd.start = 1'b1;
            state_in  = sha256h_pkg::ST_FULL_WAIT;
         end
         sha256h_pkg::ST_FULL_WAIT: begin
            if (done)
               state_in = fin_ff ? sha256h_pkg::ST_PAD : sha256h_pkg::ST_IDLE;
         end
         sha256h_pkg::ST_PAD: begin
            cmd.start = 1'b1;
            blk       = pad_blk;
            if (32'(fill_ff) >= sha256h_pkg::PAD_LIMIT) begin
               state_in = sha256h_pkg::ST_PAD_WAIT;
            end else begin
               blk[14]  = count_ff[60:29];
               blk[15]  = {count_ff[28:0], 3'b000};
               state_in = sha256h_pkg::ST_LEN_WAIT;
            end
         end
         sha256h_pkg::ST_PAD_WAIT: begin
            if (done) state_in = sha256h_pkg::ST_LEN;
         end
         sha256h_pkg::ST_LEN: begin
            cmd.start = 1'b1;
            for (int j = 0; j < 14; j++) blk[j] = '0;
            blk[14]  = count_ff[60:29];
            blk[15]  = {count_ff[28:0], 3'b000};
            state_in = sha256h_pkg::ST_LEN_WAIT;
         end
         sha256h_pkg::ST_LEN_WAIT: begin
            idx_in = '0;
            if (done) state_in = sha256h_pkg::ST_EMIT;
         end
         sha256h_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  cmd.init = 1'b1;
                  fill_in  = '0;
                  count_in = '0;
                  state_in = sha256h_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha256h_pkg::ST_IDLE;
      endcase
   end

   assign rsp_digest_word = hash[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256h_pkg::ST_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
         fin_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         fin_ff   <= fin_in;
         idx_ff   <= idx_in;
      end
   end

   // byte 0 of each word is its most significant byte
   always_ff @(posedge clock) begin
      if (accept && req_byte_valid)
         buf_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= req_data_byte;
   end

endmodule
`default_nettype wire
